// File: rtl/core/epbc_pkg.sv
// Shared types and constants of the edge pixel boundary classifier.
// Depends on nothing; the core takes names from here by scope.
package epbc_pkg;

	// Frame store geometry defaults
	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_ROWS_DEF = 256;

	// Operation codes
	localparam logic OP_STORE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// Boundary classes
	localparam logic [1:0] CLASS_NONE    = 2'd0;
	localparam logic [1:0] CLASS_WET     = 2'd1;
	localparam logic [1:0] CLASS_SIMILAR = 2'd2;
	localparam logic [1:0] CLASS_GAPS    = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SALIENCY_SPLIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_HUE_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_HUE_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TREMOR_LIMIT   = 3'd5;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [8:0]  FRAME_COLS_RST     = 9'd256;
	localparam logic [8:0]  FRAME_ROWS_RST     = 9'd256;
	localparam logic [15:0] SALIENCY_SPLIT_RST = 16'd19661;
	localparam logic [6:0]  NEAR_HUE_LIMIT_RST = 7'd10;
	localparam logic [6:0]  FAR_HUE_LIMIT_RST  = 7'd45;
	localparam logic [7:0]  TREMOR_LIMIT_RST   = 8'd45;

	// Hue range in half degrees
	localparam logic [7:0] HUE_MAX  = 8'd179;
	localparam logic [7:0] HUE_SPAN = 8'd180;

	// Square root: 28-bit padded radicand, two digits per cycle
	localparam int ROOT_CYCLES = 7;
	localparam logic [2:0] ROOT_LAST = 3'(ROOT_CYCLES - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_STEP,
		ST_CHECK,
		ST_READ_F,
		ST_READ_B,
		ST_CMP,
		ST_RESULT
	} state_t;

endpackage

// File: rtl/core/edge_pixel_boundary_classifier_core.sv
// Edge pixel boundary classifier core: frame store, gradient step unit and classifier.
// Depends on epbc_pkg (types, codes, register indexes, reset values).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------------
//  in      | to core   | in_valid/in_stall  | opcode col row hue sat val grad_x grad_y
//          |           |                    | is_edge saliency
//  out     | from core | out_valid/out_stall| boundary_class
//  cfg     | to core   | cfg_wr_en          | cfg_index cfg_data
//
// A store transaction writes the frame store at the accepting edge.
// A classify transaction runs from accept to the next accept through squares, sum, a square
// root unit (two root digits a cycle), step, border check, two reads of the single-port
// frame store, compare and result. Not an edge or pixel outside the frame: straight to the
// result. Zero gradient: from the square root straight to the result.
// Reset clears the control state, the output valid and the configuration registers; the
// frame store holds nothing defined until written and needs no clearing pass.
// A result waiting on out_stall holds only the result stage; a new transaction may be taken
// as long as the core is otherwise idle.
module edge_pixel_boundary_classifier_core #(
	parameter int MAX_COLS = epbc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = epbc_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [7:0]                      col,
	input  logic [7:0]                      row,
	input  logic [7:0]                      hue,
	input  logic [7:0]                      sat,
	input  logic [7:0]                      val,
	input  logic signed [12:0]              grad_x,
	input  logic signed [12:0]              grad_y,
	input  logic                            is_edge,
	input  logic [15:0]                     saliency,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      boundary_class,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [epbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [epbc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [8:0]  frame_cols_q;
	logic [8:0]  frame_rows_q;
	logic [15:0] saliency_split_q;
	logic [6:0]  near_hue_limit_q;
	logic [6:0]  far_hue_limit_q;
	logic [7:0]  tremor_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q     <= epbc_pkg::FRAME_COLS_RST;
			frame_rows_q     <= epbc_pkg::FRAME_ROWS_RST;
			saliency_split_q <= epbc_pkg::SALIENCY_SPLIT_RST;
			near_hue_limit_q <= epbc_pkg::NEAR_HUE_LIMIT_RST;
			far_hue_limit_q  <= epbc_pkg::FAR_HUE_LIMIT_RST;
			tremor_limit_q   <= epbc_pkg::TREMOR_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				epbc_pkg::REG_FRAME_COLS:     frame_cols_q     <= cfg_data[8:0];
				epbc_pkg::REG_FRAME_ROWS:     frame_rows_q     <= cfg_data[8:0];
				epbc_pkg::REG_SALIENCY_SPLIT: saliency_split_q <= cfg_data[15:0];
				epbc_pkg::REG_NEAR_HUE_LIMIT: near_hue_limit_q <= cfg_data[6:0];
				epbc_pkg::REG_FAR_HUE_LIMIT:  far_hue_limit_q  <= cfg_data[6:0];
				epbc_pkg::REG_TREMOR_LIMIT:   tremor_limit_q   <= cfg_data[7:0];
				default: ; // unused indexes drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------
	// A position lies in the frame in use when it is non-negative and below both the register and the store size.
	function automatic logic in_frame(input logic signed [9:0] pos, input logic [8:0] lim,
			input int maxv);
		in_frame = !pos[9] && (pos[8:0] < lim) && (32'(pos[8:0]) < maxv);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [8:0] x, input logic [8:0] y);
		addr_of = ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x);
	endfunction

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	epbc_pkg::state_t state_q, state_d;

	logic in_acc;
	logic load_out;
	logic early_fail;
	logic pos_ok;
	logic root_zero;
	logic [2:0] root_cnt_q;

	assign in_stall = (state_q != epbc_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// A classify transaction that is not an edge or whose own pixel lies outside goes straight
	// to the result with class none.
	assign early_fail = !is_edge ||
		!in_frame($signed({2'b00, col}), frame_cols_q, MAX_COLS) ||
		!in_frame($signed({2'b00, row}), frame_rows_q, MAX_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			epbc_pkg::ST_IDLE: begin
				if (in_acc && opcode == epbc_pkg::OP_CLASSIFY) begin
					state_d = early_fail ? epbc_pkg::ST_RESULT : epbc_pkg::ST_SQUARE;
				end
			end
			epbc_pkg::ST_SQUARE: state_d = epbc_pkg::ST_SUM;
			epbc_pkg::ST_SUM:    state_d = epbc_pkg::ST_ROOT;
			epbc_pkg::ST_ROOT: begin
				if (root_cnt_q == epbc_pkg::ROOT_LAST) begin
					state_d = root_zero ? epbc_pkg::ST_RESULT : epbc_pkg::ST_STEP;
				end
			end
			epbc_pkg::ST_STEP:  state_d = epbc_pkg::ST_CHECK;
			epbc_pkg::ST_CHECK: state_d = pos_ok ? epbc_pkg::ST_READ_F : epbc_pkg::ST_RESULT;
			epbc_pkg::ST_READ_F: state_d = epbc_pkg::ST_READ_B;
			epbc_pkg::ST_READ_B: state_d = epbc_pkg::ST_CMP;
			epbc_pkg::ST_CMP:    state_d = epbc_pkg::ST_RESULT;
			epbc_pkg::ST_RESULT: begin
				// hold until the output register is free or being emptied
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = epbc_pkg::ST_IDLE;
				end
			end
			default: state_d = epbc_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Captured classify operands
	// ------------------------------------------------------------------
	logic [7:0]  col_q, row_q;
	logic [15:0] saliency_q;
	logic [12:0] ax_q, ay_q;
	logic        nx_q, ny_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q      <= col;
			row_q      <= row;
			saliency_q <= saliency;
			nx_q       <= grad_x[12];
			ny_q       <= grad_y[12];
			ax_q       <= grad_x[12] ? 13'(-grad_x) : 13'(grad_x);
			ay_q       <= grad_y[12] ? 13'(-grad_y) : 13'(grad_y);
		end
	end

	// ------------------------------------------------------------------
	// Squared magnitude
	// ------------------------------------------------------------------
	logic [25:0] sqx_full, sqy_full;
	logic [24:0] sqx_q, sqy_q;

	assign sqx_full = ax_q * ax_q;
	assign sqy_full = ay_q * ay_q;

	always_ff @(posedge clk) begin
		if (state_q == epbc_pkg::ST_SQUARE) begin
			sqx_q <= sqx_full[24:0];
			sqy_q <= sqy_full[24:0];
		end
	end

	// ------------------------------------------------------------------
	// Square root unit: digit by digit, two digits a cycle
	// ------------------------------------------------------------------
	logic [27:0] rad_q;
	logic [16:0] rem_q;
	logic [13:0] root_q;
	logic [16:0] rem_d;
	logic [13:0] root_d;

	always_comb begin
		logic [16:0] part;
		logic [16:0] trial;
		logic [1:0]  digit;
		rem_d  = rem_q;
		root_d = root_q;
		for (int i = 0; i < 2; i++) begin
			digit = (i == 0) ? rad_q[27:26] : rad_q[25:24];
			part  = {rem_d[14:0], digit};
			trial = {1'b0, root_d, 2'b01};
			if (part >= trial) begin
				rem_d  = part - trial;
				root_d = {root_d[12:0], 1'b1};
			end else begin
				rem_d  = part;
				root_d = {root_d[12:0], 1'b0};
			end
		end
	end

	assign root_zero = (root_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_cnt_q <= '0;
		end else if (state_q == epbc_pkg::ST_SUM) begin
			root_cnt_q <= '0;
		end else if (state_q == epbc_pkg::ST_ROOT) begin
			root_cnt_q <= root_cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == epbc_pkg::ST_SUM) begin
			rad_q  <= {2'b00, 26'(sqx_q) + 26'(sqy_q)};
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == epbc_pkg::ST_ROOT) begin
			rad_q  <= {rad_q[23:0], 4'b0000};
			rem_q  <= rem_d;
			root_q <= root_d;
		end
	end

	// ------------------------------------------------------------------
	// Step along the gradient: component * 3 / magnitude lies in 0..3, so compares suffice
	// ------------------------------------------------------------------
	logic [14:0] mag1, mag2, mag3;
	logic [14:0] tx, ty;
	logic [1:0]  qx, qy;
	logic signed [2:0] sx_q, sy_q;

	assign mag1 = 15'(root_q);
	assign mag2 = 15'({root_q, 1'b0});
	assign mag3 = mag2 + mag1;
	assign tx   = 15'({ax_q, 1'b0}) + 15'(ax_q);
	assign ty   = 15'({ay_q, 1'b0}) + 15'(ay_q);

	always_comb begin
		priority if (tx >= mag3) qx = 2'd3;
		else if (tx >= mag2)     qx = 2'd2;
		else if (tx >= mag1)     qx = 2'd1;
		else                     qx = 2'd0;
		priority if (ty >= mag3) qy = 2'd3;
		else if (ty >= mag2)     qy = 2'd2;
		else if (ty >= mag1)     qy = 2'd1;
		else                     qy = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (state_q == epbc_pkg::ST_STEP) begin
			sx_q <= nx_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
			sy_q <= ny_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		end
	end

	// ------------------------------------------------------------------
	// Front and back positions, border check and store addresses
	// ------------------------------------------------------------------
	logic signed [9:0] fx, fy, bx, by;
	logic [ADDR_W-1:0] front_addr_q, back_addr_q;

	assign fx = $signed({2'b00, col_q}) + 10'(sx_q);
	assign fy = $signed({2'b00, row_q}) + 10'(sy_q);
	assign bx = $signed({2'b00, col_q}) - 10'(sx_q);
	assign by = $signed({2'b00, row_q}) - 10'(sy_q);

	assign pos_ok = in_frame(fx, frame_cols_q, MAX_COLS) &&
		in_frame(fy, frame_rows_q, MAX_ROWS) &&
		in_frame(bx, frame_cols_q, MAX_COLS) &&
		in_frame(by, frame_rows_q, MAX_ROWS);

	always_ff @(posedge clk) begin
		if (state_q == epbc_pkg::ST_CHECK) begin
			front_addr_q <= addr_of(fx[8:0], fy[8:0]);
			back_addr_q  <= addr_of(bx[8:0], by[8:0]);
		end
	end

	// ------------------------------------------------------------------
	// Frame store: single port, registered read
	// ------------------------------------------------------------------
	logic [23:0]       mem [DEPTH];
	logic [23:0]       rd_q;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [7:0]        hue_sat;

	assign hue_sat = (hue > epbc_pkg::HUE_MAX) ? epbc_pkg::HUE_MAX : hue;
	// Stores outside the store geometry are dropped.
	assign mem_we  = in_acc && opcode == epbc_pkg::OP_STORE &&
		(32'(col) < MAX_COLS) && (32'(row) < MAX_ROWS);

	always_comb begin
		unique case (state_q)
			epbc_pkg::ST_READ_F: mem_addr = front_addr_q;
			epbc_pkg::ST_READ_B: mem_addr = back_addr_q;
			default:             mem_addr = addr_of({1'b0, col}, {1'b0, row});
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= {val, sat, hue_sat};
		end
		rd_q <= mem[mem_addr];
	end

	// ------------------------------------------------------------------
	// Classification
	// ------------------------------------------------------------------
	logic [23:0] front_q;
	logic [7:0]  hf, hb, hue_d, hue_gap, sat_min, val_min;
	logic [6:0]  hue_lim;
	logic [1:0]  cls;
	logic [1:0]  class_q;

	always_ff @(posedge clk) begin
		if (state_q == epbc_pkg::ST_READ_B) begin
			front_q <= rd_q;
		end
	end

	assign hf      = front_q[7:0];
	assign hb      = rd_q[7:0];
	assign hue_d   = (hf > hb) ? hf - hb : hb - hf;
	assign hue_gap = (hue_d < epbc_pkg::HUE_SPAN - hue_d) ? hue_d : epbc_pkg::HUE_SPAN - hue_d;
	assign hue_lim = (saliency_q < saliency_split_q) ? near_hue_limit_q : far_hue_limit_q;
	assign sat_min = (front_q[15:8] < rd_q[15:8]) ? front_q[15:8] : rd_q[15:8];
	assign val_min = (front_q[23:16] < rd_q[23:16]) ? front_q[23:16] : rd_q[23:16];

	always_comb begin
		priority if (hue_gap < 8'(hue_lim)) begin
			cls = epbc_pkg::CLASS_WET;
		end else if (hue_d < tremor_limit_q || sat_min < tremor_limit_q ||
				val_min < tremor_limit_q) begin
			cls = epbc_pkg::CLASS_SIMILAR;
		end else begin
			cls = epbc_pkg::CLASS_GAPS;
		end
	end

	// Every path but the compare leaves class none.
	always_ff @(posedge clk) begin
		if (state_q == epbc_pkg::ST_CMP) begin
			class_q <= cls;
		end else if (state_q != epbc_pkg::ST_RESULT) begin
			class_q <= epbc_pkg::CLASS_NONE;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic       out_valid_q;
	logic [1:0] out_class_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_class_q <= class_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign boundary_class = out_class_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && out_stall))
		else $error("result loaded over a pending result");

	a_store_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && opcode == epbc_pkg::OP_STORE) |=> state_q == epbc_pkg::ST_IDLE)
		else $error("store transaction started classify work");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == epbc_pkg::ST_ROOT) |-> root_cnt_q <= epbc_pkg::ROOT_LAST)
		else $error("square root counter overran");

	a_read_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == epbc_pkg::ST_READ_F) |->
			($past(state_q) == epbc_pkg::ST_CHECK && $past(pos_ok)))
		else $error("frame store read without a passing border check");

endmodule
